// ----- hdl/gsh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gsh_pkg;

    // coordinate limits in 1e-7 degree
    localparam logic signed [31:0] LAT_HALF = 32'sd900000000;
    localparam logic signed [31:0] LNG_HALF = 32'sd1800000000;

    // full span of each range, the divisor of the bisection
    localparam logic [31:0] LAT_SPAN = 32'd1800000000;
    localparam logic [31:0] LNG_SPAN = 32'd3600000000;

    // geohash length
    localparam logic [3:0] DEFAULT_CHARS = 4'd6;
    localparam logic [3:0] LIMIT_CHARS   = 4'd12;
    localparam logic [3:0] MAX_CHARS     = 4'd12;

    localparam int unsigned DEF_QUEUE_DEPTH = 4;

    // base32 alphabet, first character in the top byte
    localparam logic [255:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    // classified item handed from front to back
    typedef struct packed {
        logic        ok;
        logic [3:0]  char_num;
        logic [31:0] lat_off;
        logic [31:0] lng_off;
    } gsh_entry_t;

    // ascii code of one base32 symbol
    function automatic logic [6:0] gsh_char(input logic [4:0] sym);
        logic [4:0] pos;
        pos = 5'd31 - sym;
        return ALPHABET[{pos, 3'b000} +: 7];
    endfunction

    // one bisection step as a restoring division step: {bit, remainder}
    function automatic logic [32:0] gsh_bisect(input logic [31:0] r, input logic [31:0] span);
        logic [32:0] dbl;
        logic [32:0] diff;
        dbl  = {r, 1'b0};
        diff = dbl - {1'b0, span};
        if (dbl > {1'b0, span})
            return {1'b1, diff[31:0]};
        else
            return {1'b0, dbl[31:0]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/geohash_encoder.sv -----
// with the back end idle, an accepted item passes the queue slot and the working registers before
// its first character leaves the output register; one character per cycle while out_stall is low,
// an item giving its geohash length in characters (char_count, or 6 outside 1..12; one rejected
// result for coordinates out of range), each from five bisection steps as restoring division steps
// reset: asynchronous, active low; clears the queue and output valid,
// char_count returns to 6
`timescale 1ns / 1ps
`default_nettype none

module geohash_encoder #(
    parameter int unsigned QUEUE_DEPTH = gsh_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic        [3:0]  cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] latitude,
    input  wire logic signed [31:0] longitude,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [6:0]  hash_char,
    output logic             [3:0]  char_index,
    output logic                    valid_res,
    output logic                    last
);
    import gsh_pkg::*;

    logic [3:0]  char_count_reg;
    logic [3:0]  char_count_next;
    gsh_entry_t  front_entry;
    gsh_entry_t  head_entry;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    // length register
    assign char_count_next = cfg_wr_en ? cfg_wr_data : char_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_count_reg <= DEFAULT_CHARS;
        else
            char_count_reg <= char_count_next;
    end

    // front end: range check and offsets
    gsh_front u_front (
        .char_count (char_count_reg),
        .latitude   (latitude),
        .longitude  (longitude),
        .entry      (front_entry)
    );

    assign in_stall = q_full;

    // queue between front and back
    gsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (head_entry)
    );

    // back end: bisection and character output
    gsh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (q_valid),
        .entry       (head_entry),
        .entry_pop   (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hash_char   (hash_char),
        .char_index  (char_index),
        .valid_res   (valid_res),
        .last        (last)
    );

`ifndef SYNTH
    // a rejected item gives one result only
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (last && char_index == 4'd0 && hash_char == 7'd0))
        else $error("rejected item result malformed");

    // characters of one item follow in order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=>
        (out_valid && char_index == $past(char_index) + 4'd1))
        else $error("character index did not advance");

    // a new item starts at character zero
    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> (!out_valid || char_index == 4'd0))
        else $error("new item did not start at index zero");
`endif

endmodule

`default_nettype wire

// ----- hdl/gsh_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsh_front (
    input  wire logic               [3:0]  char_count,
    input  wire logic signed        [31:0] latitude,
    input  wire logic signed        [31:0] longitude,
    output gsh_pkg::gsh_entry_t            entry
);
    import gsh_pkg::*;

    logic        in_range;
    logic [32:0] lat_sum;
    logic [32:0] lng_sum;
    logic [3:0]  n_sel;

    // range check, bounds themselves are in range
    assign in_range = (latitude <= LAT_HALF) && (latitude >= -LAT_HALF) &&
                      (longitude <= LNG_HALF) && (longitude >= -LNG_HALF);

    // offsets from the lower bound of each range
    assign lat_sum = {latitude[31], latitude} + {1'b0, LAT_HALF};
    assign lng_sum = {longitude[31], longitude} + {1'b0, LNG_HALF};

    // resolve geohash length
    always_comb
    begin
        if (char_count == 4'd0 || char_count > LIMIT_CHARS)
            n_sel = DEFAULT_CHARS;
        else
            n_sel = char_count;
        if (n_sel > MAX_CHARS)
            n_sel = MAX_CHARS;
    end

    assign entry.ok       = in_range;
    assign entry.char_num = n_sel;
    assign entry.lat_off  = lat_sum[31:0];
    assign entry.lng_off  = lng_sum[31:0];

endmodule

`default_nettype wire

// ----- hdl/gsh_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsh_queue #(
    parameter int unsigned DEPTH = gsh_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  gsh_pkg::gsh_entry_t      push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     pop_valid,
    output gsh_pkg::gsh_entry_t      pop_data
);
    import gsh_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gsh_entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- hdl/gsh_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsh_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 entry_valid,
    input  gsh_pkg::gsh_entry_t       entry,
    output logic                      entry_pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic               [6:0]  hash_char,
    output logic               [3:0]  char_index,
    output logic                      valid_res,
    output logic                      last
);
    import gsh_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    logic        ok_reg;
    logic        ok_next;
    logic [3:0]  n_reg;
    logic [3:0]  n_next;
    logic [3:0]  k_reg;
    logic [3:0]  k_next;
    logic [31:0] lat_r_reg;
    logic [31:0] lat_r_next;
    logic [31:0] lng_r_reg;
    logic [31:0] lng_r_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  hash_reg;
    logic [6:0]  hash_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic        vres_reg;
    logic        vres_next;
    logic        last_reg;
    logic        last_next;

    logic        adv;
    logic        emit;
    logic        load;
    logic        cur_last;
    logic [32:0] a1;
    logic [32:0] a2;
    logic [32:0] a3;
    logic [32:0] b1;
    logic [32:0] b2;
    logic [32:0] b3;
    logic [4:0]  sym;
    logic [31:0] lng_after;
    logic [31:0] lat_after;

    // three chained steps per coordinate, two or three of them are used
    assign a1 = gsh_bisect(lng_r_reg, LNG_SPAN);
    assign a2 = gsh_bisect(a1[31:0], LNG_SPAN);
    assign a3 = gsh_bisect(a2[31:0], LNG_SPAN);
    assign b1 = gsh_bisect(lat_r_reg, LAT_SPAN);
    assign b2 = gsh_bisect(b1[31:0], LAT_SPAN);
    assign b3 = gsh_bisect(b2[31:0], LAT_SPAN);

    // even characters start on longitude, odd ones on latitude
    always_comb
    begin
        if (!k_reg[0])
        begin
            sym       = {a1[32], b1[32], a2[32], b2[32], a3[32]};
            lng_after = a3[31:0];
            lat_after = b2[31:0];
        end
        else
        begin
            sym       = {b1[32], a1[32], b2[32], a2[32], b3[32]};
            lng_after = a2[31:0];
            lat_after = b3[31:0];
        end
    end

    // handshake between working registers and output register
    assign adv       = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && adv;
    assign cur_last  = !ok_reg || (k_reg + 4'd1 == n_reg);
    assign load      = entry_valid && (!busy_reg || (emit && cur_last));
    assign entry_pop = load;

    always_comb
    begin
        busy_next      = busy_reg;
        ok_next        = ok_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        lat_r_next     = lat_r_reg;
        lng_r_next     = lng_r_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;
        idx_next       = idx_reg;
        vres_next      = vres_reg;
        last_next      = last_reg;

        // produce one character
        if (emit)
        begin
            out_valid_next = 1'b1;
            hash_next      = ok_reg ? gsh_char(sym) : 7'd0;
            idx_next       = ok_reg ? k_reg : 4'd0;
            vres_next      = ok_reg;
            last_next      = cur_last;
            k_next         = k_reg + 4'd1;
            lat_r_next     = lat_after;
            lng_r_next     = lng_after;
            if (cur_last)
                busy_next = 1'b0;
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end

        // take the next item from the queue
        if (load)
        begin
            busy_next  = 1'b1;
            ok_next    = entry.ok;
            n_next     = entry.char_num;
            k_next     = 4'd0;
            lat_r_next = entry.lat_off;
            lng_r_next = entry.lng_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        lat_r_reg <= lat_r_next;
        lng_r_reg <= lng_r_next;
        hash_reg  <= hash_next;
        idx_reg   <= idx_next;
        vres_reg  <= vres_next;
        last_reg  <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_char  = hash_reg;
    assign char_index = idx_reg;
    assign valid_res  = vres_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ----- verif/geohash_checker.sv -----
`timescale 1ns / 1ps

module geohash_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic        [3:0]  cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic        [6:0]  hash_char,
    input  logic        [3:0]  char_index,
    input  logic               valid_res,
    input  logic               last,
    output int                 fail_count,
    output int                 pending_chars
);

    // coordinate limits in 1e-7 degree
    localparam longint LAT_LIMIT = 900000000;
    localparam longint LNG_LIMIT = 1800000000;
    localparam int     FRAC_BITS = 32;
    localparam logic [3:0] DEF_LEN = 4'd6;
    localparam logic [3:0] MAX_LEN = 4'd12;
    localparam logic [255:0] BASE32 = "0123456789bcdefghjkmnpqrstuvwxyz";

    typedef struct {
        logic [6:0] code;
        logic [3:0] pos;
        logic       ok;
        logic       fin;
    } geo_char_t;

    geo_char_t  expected_chars[$];
    logic [3:0] char_count_q;

    // bisect both ranges, longitude first, and queue one entry per character
    function automatic void predict_geohash(input logic signed [31:0] lat,
                                            input logic signed [31:0] lng);
        logic [63:0] lat_pos, lng_pos, lat_lo, lng_lo, lat_w, lng_w, half, mid;
        logic [3:0]  len;
        logic [4:0]  sym;
        logic        on_lng;
        logic        upper;
        geo_char_t   entry;
        int          k, b;

        len = char_count_q;
        if (len == 4'd0 || len > MAX_LEN)
            len = DEF_LEN;

        // out of range coordinates give one rejected character
        if (longint'(lat) > LAT_LIMIT || longint'(lat) < -LAT_LIMIT ||
            longint'(lng) > LNG_LIMIT || longint'(lng) < -LNG_LIMIT)
        begin
            entry.code = 7'd0;
            entry.pos  = 4'd0;
            entry.ok   = 1'b0;
            entry.fin  = 1'b1;
            expected_chars.push_back(entry);
            return;
        end

        lat_pos = 64'(longint'(lat) + LAT_LIMIT) << FRAC_BITS;
        lng_pos = 64'(longint'(lng) + LNG_LIMIT) << FRAC_BITS;
        lat_lo  = 64'd0;
        lng_lo  = 64'd0;
        lat_w   = 64'(2 * LAT_LIMIT) << FRAC_BITS;
        lng_w   = 64'(2 * LNG_LIMIT) << FRAC_BITS;
        on_lng  = 1'b1;

        for (k = 0; k < int'(len); k++)
        begin
            sym = 5'd0;
            for (b = 0; b < 5; b++)
            begin
                // equal to the midpoint stays in the lower half
                if (on_lng)
                begin
                    half  = lng_w >> 1;
                    mid   = lng_lo + half;
                    upper = (lng_pos > mid);
                    if (upper)
                        lng_lo = mid;
                    lng_w = half;
                end
                else
                begin
                    half  = lat_w >> 1;
                    mid   = lat_lo + half;
                    upper = (lat_pos > mid);
                    if (upper)
                        lat_lo = mid;
                    lat_w = half;
                end
                sym    = {sym[3:0], upper};
                on_lng = !on_lng;
            end
            entry.code = BASE32[8 * (31 - int'(sym)) +: 7];
            entry.pos  = k[3:0];
            entry.ok   = 1'b1;
            entry.fin  = (k == int'(len) - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    // one field of a character against its expectation
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // follow config writes, predict accepted items, compare accepted characters
    always @(posedge clk or negedge rst_n)
    begin : monitor
        geo_char_t want;
        if (!rst_n)
        begin
            char_count_q = DEF_LEN;
            expected_chars.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                char_count_q = cfg_wr_data;
            if (in_valid && !in_stall)
                predict_geohash(latitude, longitude);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character, expected none, actual %0d idx %0d ok %b last %b",
                             $time, hash_char, char_index, valid_res, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    check_field("hash_char", want.code, hash_char);
                    check_field("char_index", want.pos, char_index);
                    check_field("valid_res", want.ok, valid_res);
                    check_field("last", want.fin, last);
                end
            end
        end
        pending_chars = expected_chars.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES = 200;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic        [3:0]  cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic               out_valid;
    logic               out_stall;
    logic        [6:0]  hash_char;
    logic        [3:0]  char_index;
    logic               valid_res;
    logic               last;
    int                 fail_count;
    int                 pending_chars;

    // idling controls for the sender and the receiver
    logic tx_steady;
    logic rx_steady;
    logic hold_request;

    geohash_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .latitude    (latitude),
        .longitude   (longitude),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hash_char   (hash_char),
        .char_index  (char_index),
        .valid_res   (valid_res),
        .last        (last)
    );

    geohash_checker geohash_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .latitude      (latitude),
        .longitude     (longitude),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hash_char     (hash_char),
        .char_index    (char_index),
        .valid_res     (valid_res),
        .last          (last),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stall before each character, long hold on request
    initial
    begin : receiver
        int stall_len;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_len = HOLD_CYCLES;
            end
            else
                stall_len = rx_steady ? 0 : $urandom_range(0, 5);
            out_stall = (stall_len != 0);
            if (stall_len != 0)
            begin
                repeat (stall_len) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // offer one coordinate pair after a random gap, return once accepted
    task automatic send_coord(input logic signed [31:0] lat, input logic signed [31:0] lng);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        latitude  = lat;
        longitude = lng;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // value at an edge or the midpoint of a range, jittered by up to two units
    function automatic logic [31:0] near_edge(input logic [31:0] limit);
        logic [31:0] base;
        case ($urandom_range(0, 2))
            0:       base = limit;
            1:       base = -limit;
            default: base = 32'd0;
        endcase
        return base + $urandom_range(0, 4) - 32'd2;
    endfunction

    // mostly in-range pairs, some at the edges, some raw 32-bit noise
    task automatic run_random(input int count);
        int          j;
        int          pick;
        logic [31:0] lat;
        logic [31:0] lng;
        for (j = 0; j < count; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                lat = $urandom_range(0, 32'd1800000000) - 32'd900000000;
                lng = $urandom_range(0, 32'd3600000000) - 32'd1800000000;
            end
            else if (pick < 85)
            begin
                lat = near_edge(32'd900000000);
                lng = near_edge(32'd1800000000);
            end
            else
            begin
                lat = $urandom;
                lng = $urandom;
            end
            send_coord(lat, lng);
        end
    endtask

    // write the length register once the block has drained
    task automatic set_char_count(input logic [3:0] value);
        in_valid = 1'b0;
        while (pending_chars != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic signed [31:0] dir_lat [15];
        logic signed [31:0] dir_lng [15];
        logic        [3:0]  cfg_plan [9];
        int                 i;
        int                 waited;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 4'd0;
        in_valid     = 1'b0;
        latitude     = 32'sd0;
        longitude    = 32'sd0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;

        // midpoints, range bounds, just outside, integer extremes, real places
        dir_lat = '{32'sd0, 32'sd900000000, -32'sd900000000, 32'sd900000001,
                    -32'sd900000001, 32'sd0, 32'sd0, 32'h80000000, 32'h7fffffff,
                    32'sd450000000, -32'sd450000000, 32'sd1, -32'sd1,
                    32'sd473000000, -32'sd338000000};
        dir_lng = '{32'sd0, 32'sd1800000000, -32'sd1800000000, 32'sd0,
                    32'sd0, 32'sd1800000001, -32'sd1800000001, 32'h80000000,
                    32'h7fffffff, 32'sd900000000, -32'sd900000000, 32'sd1, -32'sd1,
                    -32'sd1223000000, 32'sd1512000000};
        // longest, shortest, the out-of-range values, then a mix
        cfg_plan = '{4'd12, 4'd1, 4'd0, 4'd15, 4'd13, 4'd9, 4'd2, 4'd11, 4'd5};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed items under the reset length
        for (i = 0; i < 15; i++)
            send_coord(dir_lat[i], dir_lng[i]);

        // random phases, one length setting each
        for (i = 0; i < 9; i++)
        begin
            set_char_count(cfg_plan[i]);
            tx_steady = (i == 0 || i == 2 || i == 6);
            rx_steady = (i == 2 || i == 5);
            // back up the output while the input keeps coming
            if (i == 0)
                hold_request = 1'b1;
            run_random(31);
        end
        in_valid = 1'b0;

        // drain, then let any stray character show up
        waited = 0;
        while (pending_chars != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);

        if (fail_count == 0 && pending_chars == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
